[rtl/rc_lowpass_with_invalid_samples_top_macros.svh]
// Assertion macros shared by the low-pass filter RTL.
// Needs a clock named clock and a synchronous reset named reset in the using module.
`ifndef RC_LOWPASS_WITH_INVALID_SAMPLES_TOP_MACROS_SVH
`define RC_LOWPASS_WITH_INVALID_SAMPLES_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RCLP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition must never be true outside reset.
`define RCLP_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[rtl/rclp_pkg.sv]
// Types and constants of the RC low-pass filter with sample valid flags.
// No dependencies; used by rclp_alu, rclp_core and the top level.
package rclp_pkg;

   // Width of the shared adder; holds the remainder of the alpha division.
   localparam int ALU_W    = 64;
   localparam int CNT_W    = 5;
   localparam int OPB_W    = 32;
   localparam int CUTOFF_W = 20;
   localparam int TSTEP_W  = 20;

   // round(2*pi*2^19)
   localparam int TWO_PI_W = 22;
   localparam logic [TWO_PI_W-1:0] TWO_PI_Q19 = 22'd3294199;

   // 1e8 * 2^19: one second in microseconds times centihertz, in Q19.
   localparam logic [ALU_W-1:0] DEN_BASE = 64'd52428800000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_CT,
      ST_MUL_K,
      ST_DEN,
      ST_DIV,
      ST_DIFF,
      ST_NEG,
      ST_SCALE,
      ST_UPD,
      ST_DONE
   } core_state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_op_type;

endpackage

[rtl/rc_lowpass_with_invalid_samples_top.sv]
// Top level of the first-order RC low-pass filter with sample valid flags.
// Depends on rclp_pkg, rclp_core (with rclp_alu) and the assertion macro header.
//
// Usage:
//   Each req_ transaction carries a signed Q16.16 sample, its valid flag (low stands
//   for NaN) and the time since the previous sample in microseconds. Each one yields
//   exactly one rsp_ transaction with the new smoothed value and its valid flag.
//   The csr_ channel writes the cutoff frequency in 0.01 Hz; zero bypasses the
//   filter. It is always ready and should only be written while no transaction is
//   in flight.
//   When filtering, alpha = w/(1+w) with w = 2*pi*fc*dt is formed by one shared
//   64-bit adder: 20 steps for cutoff times time step, 22 steps for the 2*pi
//   constant, one quotient bit per step of the division, and one alpha bit per
//   step of the scaling multiply. req_ready returns together with rsp_valid, so
//   no new sample is taken before the last result is in the output register.
//   A bypassed or invalid sample goes straight from idle to the done state.
//   The result sits in an output register; a stalled receiver holds it there
//   while the next sample is already being worked on, and the core waits only
//   when it finishes with the register still full.
//   Synchronous reset clears the cutoff to zero and marks the stored value invalid,
//   so the first valid sample after reset passes straight through.
`include "rc_lowpass_with_invalid_samples_top_macros.svh"

module rc_lowpass_with_invalid_samples_top #(
   parameter int SAMPLE_WIDTH        = 32,
   parameter int ALPHA_FRACTION_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample,
   input  logic                                  req_sample_valid,
   input  logic [rclp_pkg::TSTEP_W-1:0]          req_time_step_us,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_filtered,
   output logic                                  rsp_filtered_valid,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rclp_pkg::CUTOFF_W-1:0]         csr_cutoff_centihertz
);

   logic [rclp_pkg::CUTOFF_W-1:0]  cutoff_ff, cutoff_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic                           rsp_filtered_valid_ff, rsp_filtered_valid_in;

   rclp_pkg::core_stat_type        stat;
   logic                           start;
   logic                           out_free;
   logic                           load_rsp;
   logic signed [SAMPLE_WIDTH-1:0] core_filtered;
   logic                           core_filtered_valid;

   // The output register is free when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign start     = req_valid && stat.idle;
   assign load_rsp  = stat.done && out_free;
   assign req_ready = stat.idle;
   assign csr_ready = 1'b1;

   rclp_core #(
      .SAMPLE_WIDTH        (SAMPLE_WIDTH),
      .ALPHA_FRACTION_BITS (ALPHA_FRACTION_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .sample         (req_sample),
      .sample_valid   (req_sample_valid),
      .time_step_us   (req_time_step_us),
      .cutoff         (cutoff_ff),
      .out_free       (out_free),
      .stat           (stat),
      .filtered       (core_filtered),
      .filtered_valid (core_filtered_valid)
   );

   always_comb begin
      cutoff_in             = csr_valid ? csr_cutoff_centihertz : cutoff_ff;
      rsp_valid_in          = rsp_valid_ff;
      rsp_filtered_in       = rsp_filtered_ff;
      rsp_filtered_valid_in = rsp_filtered_valid_ff;
      if (load_rsp) begin
         rsp_valid_in          = 1'b1;
         rsp_filtered_in       = core_filtered;
         rsp_filtered_valid_in = core_filtered_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cutoff_ff    <= cutoff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_filtered_ff       <= rsp_filtered_in;
      rsp_filtered_valid_ff <= rsp_filtered_valid_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered       = rsp_filtered_ff;
   assign rsp_filtered_valid = rsp_filtered_valid_ff;

   `RCLP_ASSERT(a_accept_busy, (req_valid && req_ready) |=> !req_ready, "core did not go busy after accept")
   `RCLP_ASSERT(a_invalid_rsp_zero, (rsp_valid && !rsp_filtered_valid) |-> rsp_filtered == '0, "invalid result carries nonzero value")
   `RCLP_NEVER(a_no_overwrite, stat.done && rsp_valid_ff && !rsp_ready && !$stable(rsp_filtered_ff), "pending result overwritten")

endmodule

[rtl/rclp_alu.sv]
// Shared add/subtract unit of the low-pass filter sequencer.
// Depends on rclp_pkg. Bit ALU_W of the result is the carry; on subtract it means a >= b.
module rclp_alu (
   input  rclp_pkg::alu_op_type         op,
   output logic [rclp_pkg::ALU_W:0]     res
);

   logic [rclp_pkg::ALU_W-1:0] b_eff;

   assign b_eff = op.sub ? ~op.b : op.b;
   assign res   = {1'b0, op.a} + {1'b0, b_eff} + {{rclp_pkg::ALU_W{1'b0}}, op.sub};

endmodule

[rtl/rclp_core.sv]
// Sequencer and datapath registers of the low-pass filter, around one shared adder.
// Depends on rclp_pkg, rclp_alu and the assertion macro header.
`include "rc_lowpass_with_invalid_samples_top_macros.svh"

module rclp_core #(
   parameter int SAMPLE_WIDTH        = 32,
   parameter int ALPHA_FRACTION_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [SAMPLE_WIDTH-1:0]        sample,
   input  logic                                  sample_valid,
   input  logic [rclp_pkg::TSTEP_W-1:0]          time_step_us,
   input  logic [rclp_pkg::CUTOFF_W-1:0]         cutoff,
   input  logic                                  out_free,
   output rclp_pkg::core_stat_type               stat,
   output logic signed [SAMPLE_WIDTH-1:0]        filtered,
   output logic                                  filtered_valid
);

   localparam int AW = rclp_pkg::ALU_W;
   localparam int SW = SAMPLE_WIDTH;

   rclp_pkg::core_state_type state_ff, state_in;
   logic [AW-1:0]                  acc_ff, acc_in;
   logic [AW-1:0]                  opa_ff, opa_in;
   logic [rclp_pkg::OPB_W-1:0]     opb_ff, opb_in;
   logic [rclp_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                           neg_ff, neg_in;
   logic signed [SW-1:0]           x_ff, x_in;
   logic signed [SW-1:0]           y_ff, y_in;
   logic                           yv_ff, yv_in;

   rclp_pkg::alu_op_type           alu_op;
   logic [AW:0]                    alu_res;
   logic                           bypass;
   logic [AW-1:0]                  x_ext, y_ext;

   rclp_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   assign bypass = (cutoff == '0) || !yv_ff;
   assign x_ext  = {{(AW-SW){x_ff[SW-1]}}, x_ff};
   assign y_ext  = {{(AW-SW){y_ff[SW-1]}}, y_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rclp_pkg::ST_IDLE: begin
            if (start) begin
               if (bypass || !sample_valid) begin
                  state_in = rclp_pkg::ST_DONE;
               end else begin
                  state_in = rclp_pkg::ST_MUL_CT;
               end
            end
         end
         rclp_pkg::ST_MUL_CT: begin
            if (cnt_ff == '0) state_in = rclp_pkg::ST_MUL_K;
         end
         rclp_pkg::ST_MUL_K: begin
            if (cnt_ff == '0) state_in = rclp_pkg::ST_DEN;
         end
         rclp_pkg::ST_DEN:   state_in = rclp_pkg::ST_DIV;
         rclp_pkg::ST_DIV: begin
            if (cnt_ff == '0) state_in = rclp_pkg::ST_DIFF;
         end
         rclp_pkg::ST_DIFF:  state_in = rclp_pkg::ST_NEG;
         rclp_pkg::ST_NEG:   state_in = rclp_pkg::ST_SCALE;
         rclp_pkg::ST_SCALE: begin
            if (cnt_ff == '0) state_in = rclp_pkg::ST_UPD;
         end
         rclp_pkg::ST_UPD:   state_in = rclp_pkg::ST_DONE;
         rclp_pkg::ST_DONE: begin
            if (out_free) state_in = rclp_pkg::ST_IDLE;
         end
         default:            state_in = rclp_pkg::ST_IDLE;
      endcase
   end

   // Datapath control and adder operand selection.
   always_comb begin
      acc_in     = acc_ff;
      opa_in     = opa_ff;
      opb_in     = opb_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      yv_in      = yv_ff;
      alu_op.a   = acc_ff;
      alu_op.b   = '0;
      alu_op.sub = 1'b0;
      case (state_ff)
         rclp_pkg::ST_IDLE: begin
            if (start) begin
               x_in   = sample;
               acc_in = '0;
               opa_in = {{(AW-rclp_pkg::CUTOFF_W){1'b0}}, cutoff};
               opb_in = {time_step_us, {(rclp_pkg::OPB_W-rclp_pkg::TSTEP_W){1'b0}}};
               cnt_in = rclp_pkg::CNT_W'(rclp_pkg::TSTEP_W - 1);
               if (bypass) begin
                  y_in  = sample_valid ? sample : '0;
                  yv_in = sample_valid;
               end else if (!sample_valid) begin
                  y_in  = '0;
                  yv_in = 1'b0;
               end
            end
         end
         rclp_pkg::ST_MUL_CT: begin
            // cutoff * time step, time step bits taken MSB first
            alu_op.a = {acc_ff[AW-2:0], 1'b0};
            alu_op.b = opb_ff[rclp_pkg::OPB_W-1] ? opa_ff : '0;
            acc_in   = alu_res[AW-1:0];
            opb_in   = {opb_ff[rclp_pkg::OPB_W-2:0], 1'b0};
            cnt_in   = cnt_ff - rclp_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               opa_in = alu_res[AW-1:0];
               acc_in = '0;
               cnt_in = rclp_pkg::CNT_W'(rclp_pkg::TWO_PI_W - 1);
            end
         end
         rclp_pkg::ST_MUL_K: begin
            // times 2*pi in Q19, constant bits taken MSB first
            alu_op.a = {acc_ff[AW-2:0], 1'b0};
            alu_op.b = rclp_pkg::TWO_PI_Q19[cnt_ff] ? opa_ff : '0;
            acc_in   = alu_res[AW-1:0];
            cnt_in   = cnt_ff - rclp_pkg::CNT_W'(1);
         end
         rclp_pkg::ST_DEN: begin
            alu_op.b = rclp_pkg::DEN_BASE;
            opa_in   = alu_res[AW-1:0];
            opb_in   = '0;
            cnt_in   = rclp_pkg::CNT_W'(ALPHA_FRACTION_BITS - 1);
         end
         rclp_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            alu_op.a   = {acc_ff[AW-2:0], 1'b0};
            alu_op.b   = opa_ff;
            alu_op.sub = 1'b1;
            acc_in     = alu_res[AW] ? alu_res[AW-1:0] : {acc_ff[AW-2:0], 1'b0};
            opb_in     = {opb_ff[rclp_pkg::OPB_W-2:0], alu_res[AW]};
            cnt_in     = cnt_ff - rclp_pkg::CNT_W'(1);
         end
         rclp_pkg::ST_DIFF: begin
            alu_op.a   = x_ext;
            alu_op.b   = y_ext;
            alu_op.sub = 1'b1;
            acc_in     = alu_res[AW-1:0];
            neg_in     = alu_res[AW-1];
         end
         rclp_pkg::ST_NEG: begin
            alu_op.a   = '0;
            alu_op.b   = acc_ff;
            alu_op.sub = 1'b1;
            opa_in     = neg_ff ? alu_res[AW-1:0] : acc_ff;
            acc_in     = '0;
            cnt_in     = rclp_pkg::CNT_W'(ALPHA_FRACTION_BITS - 1);
         end
         rclp_pkg::ST_SCALE: begin
            // Right-shifting multiply keeps only floor(alpha * |x - y| / 2^F).
            alu_op.b = opb_ff[0] ? opa_ff : '0;
            acc_in   = alu_res[AW:1];
            opb_in   = {1'b0, opb_ff[rclp_pkg::OPB_W-1:1]};
            cnt_in   = cnt_ff - rclp_pkg::CNT_W'(1);
         end
         rclp_pkg::ST_UPD: begin
            alu_op.a   = y_ext;
            alu_op.b   = acc_ff;
            alu_op.sub = neg_ff;
            y_in       = alu_res[SW-1:0];
         end
         rclp_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rclp_pkg::ST_IDLE;
         y_ff     <= '0;
         yv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         y_ff     <= y_in;
         yv_ff    <= yv_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      x_ff   <= x_in;
   end

   assign stat.idle      = (state_ff == rclp_pkg::ST_IDLE);
   assign stat.done      = (state_ff == rclp_pkg::ST_DONE);
   assign filtered       = y_ff;
   assign filtered_valid = yv_ff;

   `RCLP_ASSERT(a_invalid_is_zero, !yv_ff |-> y_ff == '0, "invalid smoothed value is not zero")
   `RCLP_ASSERT(a_step_bounded, state_ff == rclp_pkg::ST_UPD |-> acc_ff <= opa_ff, "update step exceeds difference")
   `RCLP_ASSERT(a_done_holds, (state_ff == rclp_pkg::ST_DONE && !out_free) |=> state_ff == rclp_pkg::ST_DONE, "result dropped while output busy")
   `RCLP_NEVER(a_start_busy, start && state_ff != rclp_pkg::ST_IDLE, "start while sequencer busy")

endmodule

[bench/lowpass_checker.sv]
`timescale 1ns / 1ps
// Checker for the RC low-pass filter: predicts every smoothed value and compares results.
// Depends on rclp_pkg for the field widths; instantiated by tb_top beside the filter.
module lowpass_checker #(
   parameter int SAMPLE_WIDTH        = 32,
   parameter int ALPHA_FRACTION_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   input  logic                                req_sample_valid,
   input  logic [rclp_pkg::TSTEP_W-1:0]        req_time_step_us,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]      rsp_filtered,
   input  logic                                rsp_filtered_valid,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rclp_pkg::CUTOFF_W-1:0]       csr_cutoff_centihertz,
   output int                                  mismatch_count,
   output int                                  outstanding,
   output int                                  results_checked,
   output int                                  alpha_updates
);

   // 2*pi in Q19, and one second in microseconds times centihertz, also in Q19.
   localparam logic [63:0] TWO_PI_SCALED     = 64'd3294199;
   localparam logic [63:0] ONE_SECOND_SCALED = 64'd100000000 << 19;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] value;
      logic                    valid;
   } filter_output_type;

   logic [rclp_pkg::CUTOFF_W-1:0] cutoff;
   logic [SAMPLE_WIDTH-1:0]       held_value;
   logic                          held_valid;
   filter_output_type             pending_outputs[$];

   initial begin
      mismatch_count  = 0;
      outstanding     = 0;
      results_checked = 0;
      alpha_updates   = 0;
   end

   // Advances the stored value by one sample and returns what the filter must report.
   function automatic filter_output_type advance_filter(input logic [SAMPLE_WIDTH-1:0] x,
                                                        input logic x_ok,
                                                        input logic [rclp_pkg::TSTEP_W-1:0] dt);
      logic [63:0]        num, den, rem, alpha, mag, step;
      logic [127:0]       product;
      logic signed [63:0] x_wide, y_wide, diff, y_next;
      if (cutoff == '0 || !held_valid) begin
         held_valid = x_ok;
         held_value = x_ok ? x : '0;
      end else if (!x_ok) begin
         held_valid = 1'b0;
         held_value = '0;
      end else begin
         // alpha = w / (1 + w), one quotient bit per step.
         num   = 64'(cutoff) * 64'(dt) * TWO_PI_SCALED;
         den   = ONE_SECOND_SCALED + num;
         rem   = num;
         alpha = '0;
         for (int i = 0; i < ALPHA_FRACTION_BITS; i++) begin
            rem   = rem << 1;
            alpha = alpha << 1;
            if (rem >= den) begin
               rem      = rem - den;
               alpha[0] = 1'b1;
            end
         end
         x_wide  = $signed(x);
         y_wide  = $signed(held_value);
         diff    = x_wide - y_wide;
         mag     = diff[63] ? -diff : diff;
         product = 128'(alpha) * 128'(mag);
         step    = product[ALPHA_FRACTION_BITS +: 64];
         y_next  = diff[63] ? y_wide - $signed(step) : y_wide + $signed(step);
         held_value = y_next[SAMPLE_WIDTH-1:0];
         alpha_updates++;
      end
      return '{value: held_value, valid: held_valid};
   endfunction

   task automatic note_mismatch(input string reason, input filter_output_type want,
                                input filter_output_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected filtered=%0d valid=%0b, got filtered=%0d valid=%0b",
                  $time, reason, $signed(want.value), want.valid,
                  $signed(got.value), got.valid);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      filter_output_type want, got;
      if (reset) begin
         cutoff     = '0;
         held_value = '0;
         held_valid = 1'b0;
         pending_outputs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{value: rsp_filtered, valid: rsp_filtered_valid};
            results_checked++;
            if (pending_outputs.size() == 0) begin
               note_mismatch("result with nothing predicted", '0, got);
            end else begin
               want = pending_outputs.pop_front();
               if (got.value !== want.value || got.valid !== want.valid) begin
                  note_mismatch("wrong result", want, got);
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_outputs.push_back(advance_filter(req_sample, req_sample_valid,
                                                     req_time_step_us));
         end
         if (csr_valid && csr_ready) begin
            cutoff = csr_cutoff_centihertz;
         end
      end
      outstanding = pending_outputs.size();
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Top of the RC low-pass filter testbench: clock, reset, stimulus, idling and verdict.
// Depends on rclp_pkg, rc_lowpass_with_invalid_samples_top and lowpass_checker.
module tb_top;

   localparam int SAMPLE_WIDTH        = 32;
   localparam int ALPHA_FRACTION_BITS = 24;
   // Long enough for a filtered sample to pass through the core, with margin on top.
   localparam int LATENCY_CYCLES      = 2 * ALPHA_FRACTION_BITS + 47 + 10;
   localparam int HOLD_OFF_CYCLES     = 300;
   // The slowest legal gap between two transactions is the long hold-off plus one
   // filtered sample; the watchdog allows many times that.
   localparam int WATCHDOG_LIMIT      = 4000;
   localparam int PHASES              = 8;
   localparam int ITEMS_PER_PHASE     = 65;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic signed [SAMPLE_WIDTH-1:0]    req_sample;
   logic                              req_sample_valid;
   logic [rclp_pkg::TSTEP_W-1:0]      req_time_step_us;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [SAMPLE_WIDTH-1:0]    rsp_filtered;
   logic                              rsp_filtered_valid;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [rclp_pkg::CUTOFF_W-1:0]     csr_cutoff_centihertz;

   int mismatch_count;
   int outstanding;
   int results_checked;
   int alpha_updates;

   int samples_sent     = 0;
   int cutoff_writes    = 0;
   int hold_offs_done   = 0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit hold_off_request = 1'b0;
   // In the last phase neither side idles.
   bit calm_tail        = 1'b0;

   rc_lowpass_with_invalid_samples_top #(
      .SAMPLE_WIDTH        (SAMPLE_WIDTH),
      .ALPHA_FRACTION_BITS (ALPHA_FRACTION_BITS)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample            (req_sample),
      .req_sample_valid      (req_sample_valid),
      .req_time_step_us      (req_time_step_us),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_filtered          (rsp_filtered),
      .rsp_filtered_valid    (rsp_filtered_valid),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_cutoff_centihertz (csr_cutoff_centihertz)
   );

   // The checker watches all three channels, predicts each result and counts
   // every wrong or unexpected one; this module only drives and judges.
   lowpass_checker #(
      .SAMPLE_WIDTH        (SAMPLE_WIDTH),
      .ALPHA_FRACTION_BITS (ALPHA_FRACTION_BITS)
   ) checker_inst (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample            (req_sample),
      .req_sample_valid      (req_sample_valid),
      .req_time_step_us      (req_time_step_us),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_filtered          (rsp_filtered),
      .rsp_filtered_valid    (rsp_filtered_valid),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_cutoff_centihertz (csr_cutoff_centihertz),
      .mismatch_count        (mismatch_count),
      .outstanding           (outstanding),
      .results_checked       (results_checked),
      .alpha_updates         (alpha_updates)
   );

   // 10 ns period, starting low so the first rising edge comes at 5 ns.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offers one sample transaction at a falling edge and returns after the rising
   // edge that accepts it. Valid is left high, so a following call keeps it high
   // without a glitch; pause_sender or drain_filter lower it.
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] x, input logic x_ok,
                              input logic [rclp_pkg::TSTEP_W-1:0] dt);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_sample       <= x;
      req_sample_valid <= x_ok;
      req_time_step_us <= dt;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stops offering samples and waits until every predicted result has been
   // taken, then lets the core's full latency pass so it is surely idle.
   task automatic drain_filter();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (LATENCY_CYCLES) @(negedge clock);
   endtask

   // The cutoff may only change while no sample is in flight.
   task automatic write_cutoff(input logic [rclp_pkg::CUTOFF_W-1:0] value);
      drain_filter();
      csr_valid             <= 1'b1;
      csr_cutoff_centihertz <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cutoff_writes++;
   endtask

   // Mostly modest Q16.16 values, so that the filter tracks something smooth,
   // with full-range words and the two extremes mixed in.
   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 32'sh7FFF_FFFF;
      if (roll == 1) return 32'sh8000_0000;
      if (roll <= 4) return $urandom();
      return 32'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
   endfunction

   // Time steps: sometimes zero, often short or typical, and a good share over
   // the whole 20-bit range so that alpha also gets close to one.
   function automatic logic [rclp_pkg::TSTEP_W-1:0] pick_step();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll <= 4) return rclp_pkg::TSTEP_W'($urandom_range(1, 100));
      if (roll <= 13) return rclp_pkg::TSTEP_W'($urandom_range(100, 20000));
      return rclp_pkg::TSTEP_W'($urandom_range(0, 20'hF_FFFF));
   endfunction

   // Receiver: short random stalls, one long hold-off on request so the output
   // register fills and the input side has to stall, and no stalls at the end.
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ready        <= 1'b0;
            hold_off_request  = 1'b0;
            hold_offs_done++;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: the run is stuck if the count of quiet cycles in a row, with no
   // transaction completing on any channel, reaches WATCHDOG_LIMIT.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Watchdog expired: no transaction for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, outstanding);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      logic [rclp_pkg::CUTOFF_W-1:0] cutoff_plan [PHASES];
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_sample            = '0;
      req_sample_valid      = 1'b0;
      req_time_step_us      = '0;
      csr_valid             = 1'b0;
      csr_cutoff_centihertz = '0;
      cutoff_plan = '{20'd0, 20'd10000, 20'hF_FFFF, 20'd1, 20'd500,
                      20'($urandom_range(1, 20'hF_FFFF)), 20'($urandom_range(1, 100000)),
                      20'd2500};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The cutoff is still zero after reset, so every sample
      // passes straight through; an invalid one must come back as zero.
      send_sample(32'sh7FFF_FFFF, 1'b1, 20'd0);
      send_sample(32'sh8000_0000, 1'b1, 20'hF_FFFF);
      send_sample(32'sh1234_5678, 1'b0, 20'd1000);
      send_sample(32'sd327680, 1'b1, 20'd1000);

      // 100 Hz: real filtering starting from a stored 5.0.
      write_cutoff(20'd10000);
      send_sample(32'sh7FFF_FFFF, 1'b1, 20'd1000);
      send_sample(32'sh8000_0000, 1'b1, 20'd1000);
      // A zero time step gives alpha of zero and must leave the value alone.
      send_sample(32'sd12345, 1'b1, 20'd0);
      // An invalid sample while filtering invalidates the stored value, and the
      // next valid sample is then taken over as is.
      send_sample(32'sh7654_3210, 1'b0, 20'd500);
      send_sample(-32'sd229376, 1'b1, 20'd500);
      send_sample(32'sd6553600, 1'b1, 20'hF_FFFF);

      // Largest cutoff with the longest step: alpha just below one.
      write_cutoff(20'hF_FFFF);
      send_sample(32'sh7FFF_FFFF, 1'b1, 20'hF_FFFF);
      send_sample(32'sh8000_0000, 1'b1, 20'hF_FFFF);
      send_sample(32'sd65536, 1'b1, 20'd1);

      // Smallest non-zero cutoff: alpha tiny or zero.
      write_cutoff(20'd1);
      send_sample(32'sh7FFF_FFFF, 1'b1, 20'd1);
      send_sample(32'sh8000_0000, 1'b1, 20'hF_FFFF);

      // Random part, one cutoff per phase. About one sample in ten is invalid,
      // which also knocks the filter back into pass-through now and then. The
      // first two phases each contain one long hold-off of the receiver.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == PHASES - 1) calm_tail = 1'b1;
         write_cutoff(cutoff_plan[phase]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == 12 && phase < 2) hold_off_request = 1'b1;
            send_sample(pick_sample(), $urandom_range(0, 9) != 0, pick_step());
            if (!calm_tail && $urandom_range(0, 3) == 0) begin
               pause_sender($urandom_range(1, 3));
            end
         end
      end

      drain_filter();

      $display("Sent %0d samples under %0d cutoff writes, with %0d long receiver hold-offs.",
               samples_sent, cutoff_writes, hold_offs_done);
      $display("Checked %0d results; %0d of them came through the alpha update.",
               results_checked, alpha_updates);
      if (outstanding != 0) begin
         $display("%0d predicted results never arrived", outstanding);
      end
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[rc_lowpass_with_invalid_samples_top.f]
+incdir+rtl
rtl/rclp_pkg.sv
rtl/rclp_alu.sv
rtl/rclp_core.sv
rtl/rc_lowpass_with_invalid_samples_top.sv
bench/lowpass_checker.sv
bench/tb_top.sv
